### sv/fap_pkg.sv
// Shared types, codes and helpers for the form-urlencoded argument parser.
// No dependencies.
`default_nettype none
package fap_pkg;

  localparam int MaxArgs = 8;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  localparam logic [1:0] TY_INT  = 2'd0;
  localparam logic [1:0] TY_NAME = 2'd1;
  localparam logic [1:0] TY_STR  = 2'd2;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_HI   = 2'd1;
  localparam logic [1:0] ESC_LO   = 2'd2;

  localparam logic [1:0] NPH_LEAD  = 2'd0;
  localparam logic [1:0] NPH_WORD  = 2'd1;
  localparam logic [1:0] NPH_SPACE = 2'd2;

  localparam logic [1:0] IPH_LEAD = 2'd0;
  localparam logic [1:0] IPH_SIGN = 2'd1;
  localparam logic [1:0] IPH_DIG  = 2'd2;

  localparam logic [2:0] U8R_ANY  = 3'd0;
  localparam logic [2:0] U8R_A0BF = 3'd1;
  localparam logic [2:0] U8R_809F = 3'd2;
  localparam logic [2:0] U8R_90BF = 3'd3;
  localparam logic [2:0] U8R_808F = 3'd4;

  localparam logic CFG_COUNT = 1'b0;
  localparam logic CFG_TYPES = 1'b1;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  arg_index;
    logic [7:0]  out_byte;
    logic [31:0] int_value;
    logic        query_done;
  } res_t;

  typedef struct packed {
    logic [2:0]  cur;
    logic [1:0]  esc;
    logic [3:0]  hi;
    logic [1:0]  u8p;
    logic [2:0]  u8r;
    logic [1:0]  nph;
    logic        ngot;
    logic [1:0]  iph;
    logic        ineg;
    logic [31:0] imag;
    logic        iovf;
    logic        failed;
  } st_t;

  // up to three results from one byte
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
    res_t       r2;
  } push_t;

  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = {1'b0, c[3:0] + 4'd9};
    return v;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage
`default_nettype wire

### sv/fap_core.sv
// Per-byte decode, UTF-8 check and argument typing with the running state.
// Depends on fap_pkg.
`default_nettype none
module fap_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire logic                has_i,
  input  wire logic [7:0]          byte_i,
  input  wire logic                end_i,
  input  wire logic [3:0]          count_i,
  input  wire logic [15:0]         types_i,
  output fap_pkg::push_t           push_o
);

  typedef struct packed {
    logic           ok;
    logic           emit;
    fap_pkg::res_t  res;
    fap_pkg::st_t   st;
  } fin_t;

  fap_pkg::st_t st_q, st_d;

  function automatic logic [1:0] arg_type(logic [2:0] cur, logic [15:0] ty);
    logic [15:0] sh;
    sh = ty >> {cur, 1'b0};
    return (sh[1:0] == 2'd3) ? fap_pkg::TY_STR : sh[1:0];
  endfunction

  function automatic fap_pkg::st_t clr_arg(fap_pkg::st_t s);
    fap_pkg::st_t o;
    o      = '0;
    o.cur  = s.cur;
    o.failed = s.failed;
    return o;
  endfunction

  function automatic fin_t finish(fap_pkg::st_t s, logic fin, logic [15:0] ty,
                                 logic [2:0] last);
    fin_t f;
    logic [1:0] t;
    t = arg_type(s.cur, ty);
    f.ok = 1'b1;
    f.emit = 1'b0;
    f.st = s;
    f.res = '0;
    if (s.esc != fap_pkg::ESC_NONE || s.u8p != 2'd0) f.ok = 1'b0;
    else if (t == fap_pkg::TY_INT && (s.iph != fap_pkg::IPH_DIG || s.iovf)) f.ok = 1'b0;
    else if (t == fap_pkg::TY_NAME && !s.ngot) f.ok = 1'b0;
    else if (fin && s.cur != last) f.ok = 1'b0;
    else if (!fin && s.cur >= last) f.ok = 1'b0;
    else begin
      f.emit = 1'b1;
      f.res.kind = fap_pkg::KIND_DONE;
      f.res.arg_index = s.cur;
      f.res.query_done = fin;
      if (t == fap_pkg::TY_INT) f.res.int_value = s.ineg ? (32'd0 - s.imag) : s.imag;
      if (!fin) begin
        f.st = clr_arg(s);
        f.st.cur = s.cur + 3'd1;
      end
    end
    return f;
  endfunction

  always_comb begin
    fap_pkg::st_t  s;
    fap_pkg::res_t r;
    fin_t          f;
    logic          ok, take, amp, dig;
    logic [7:0]    c;
    logic [4:0]    h;
    logic [2:0]    last;
    logic [3:0]    cnt;
    logic [7:0]    lo, hi;
    logic [35:0]   m, lim;
    s = st_q;
    push_o = '0;
    ok = 1'b1;
    take = 1'b0;
    amp = 1'b0;
    c = byte_i;
    h = fap_pkg::hex_val(byte_i);
    r = '0;
    f = '0;
    lo = 8'h80;
    hi = 8'hBF;
    m = '0;
    lim = '0;
    dig = 1'b0;
    cnt = (count_i == 4'd0) ? 4'd1 :
          (count_i > 4'(fap_pkg::MaxArgs)) ? 4'(fap_pkg::MaxArgs) : count_i;
    last = 3'(cnt - 4'd1);

    if (!st_q.failed) begin
      if (has_i) begin
        if (s.esc == fap_pkg::ESC_HI) begin
          if (h[4]) ok = 1'b0;
          else begin
            s.hi = h[3:0];
            s.esc = fap_pkg::ESC_LO;
          end
        end else if (s.esc == fap_pkg::ESC_LO) begin
          if (h[4]) ok = 1'b0;
          else begin
            s.esc = fap_pkg::ESC_NONE;
            c = {s.hi, h[3:0]};
            take = 1'b1;
          end
        end else if (byte_i == 8'h26) amp = 1'b1;
        else if (byte_i == 8'h25) s.esc = fap_pkg::ESC_HI;
        else if (byte_i == 8'h2B) begin
          c = 8'h20;
          take = 1'b1;
        end else take = 1'b1;
      end

      if (take) begin
        // UTF-8 sequence check
        if (s.u8p == 2'd0) begin
          if (c == 8'h00 || (c >= 8'h80 && c < 8'hC2) || c > 8'hF4) ok = 1'b0;
          else if (c < 8'h80) ;
          else if (c < 8'hE0) begin s.u8p = 2'd1; s.u8r = fap_pkg::U8R_ANY; end
          else if (c == 8'hE0) begin s.u8p = 2'd2; s.u8r = fap_pkg::U8R_A0BF; end
          else if (c == 8'hED) begin s.u8p = 2'd2; s.u8r = fap_pkg::U8R_809F; end
          else if (c < 8'hF0) begin s.u8p = 2'd2; s.u8r = fap_pkg::U8R_ANY; end
          else if (c == 8'hF0) begin s.u8p = 2'd3; s.u8r = fap_pkg::U8R_90BF; end
          else if (c < 8'hF4) begin s.u8p = 2'd3; s.u8r = fap_pkg::U8R_ANY; end
          else begin s.u8p = 2'd3; s.u8r = fap_pkg::U8R_808F; end
        end else begin
          case (s.u8r)
            fap_pkg::U8R_A0BF: lo = 8'hA0;
            fap_pkg::U8R_809F: hi = 8'h9F;
            fap_pkg::U8R_90BF: lo = 8'h90;
            fap_pkg::U8R_808F: hi = 8'h8F;
            default: ;
          endcase
          if (c < lo || c > hi) ok = 1'b0;
          else begin
            s.u8p = s.u8p - 2'd1;
            s.u8r = fap_pkg::U8R_ANY;
          end
        end

        if (ok) begin
          r.kind = fap_pkg::KIND_BYTE;
          r.arg_index = s.cur;
          case (arg_type(s.cur, types_i))
            fap_pkg::TY_INT: begin
              dig = (c >= 8'h30 && c <= 8'h39);
              if (s.iph == fap_pkg::IPH_LEAD && fap_pkg::is_space(c)) ;
              else if (s.iph == fap_pkg::IPH_LEAD && (c == 8'h2B || c == 8'h2D)) begin
                s.ineg = (c == 8'h2D);
                s.iph = fap_pkg::IPH_SIGN;
              end else if (!dig) ok = 1'b0;
              else begin
                s.iph = fap_pkg::IPH_DIG;
                m = {4'd0, s.imag} * 36'd10 + {32'd0, c[3:0]};
                lim = s.ineg ? 36'd2147483648 : 36'd2147483647;
                if (!s.iovf) begin
                  if (m > lim) s.iovf = 1'b1;
                  else s.imag = m[31:0];
                end
              end
            end
            fap_pkg::TY_NAME: begin
              if (fap_pkg::is_space(c)) begin
                if (s.nph == fap_pkg::NPH_WORD) s.nph = fap_pkg::NPH_SPACE;
              end else if (c <= 8'h20) ok = 1'b0;
              else begin
                if (s.nph == fap_pkg::NPH_SPACE) begin
                  r.out_byte = 8'h20;
                  push_o.r0 = r;
                  push_o.n = 2'd1;
                end
                r.out_byte = c;
                if (push_o.n == 2'd0) push_o.r0 = r;
                else push_o.r1 = r;
                push_o.n = push_o.n + 2'd1;
                s.nph = fap_pkg::NPH_WORD;
                s.ngot = 1'b1;
              end
            end
            default: begin
              r.out_byte = c;
              push_o.r0 = r;
              push_o.n = 2'd1;
            end
          endcase
        end
      end

      if (amp) begin
        f = finish(s, 1'b0, types_i, last);
        ok = f.ok;
        s = f.st;
        if (f.emit) begin
          push_o.r0 = f.res;
          push_o.n = 2'd1;
        end
      end

      if (ok && end_i) begin
        f = finish(s, 1'b1, types_i, last);
        ok = f.ok;
        s = f.st;
        if (f.emit) begin
          case (push_o.n)
            2'd0: push_o.r0 = f.res;
            2'd1: push_o.r1 = f.res;
            default: push_o.r2 = f.res;
          endcase
          push_o.n = push_o.n + 2'd1;
        end
      end

      if (!ok) begin
        r = '0;
        r.kind = fap_pkg::KIND_FAIL;
        r.arg_index = s.cur;
        r.query_done = 1'b1;
        case (push_o.n)
          2'd0: push_o.r0 = r;
          2'd1: push_o.r1 = r;
          default: push_o.r2 = r;
        endcase
        push_o.n = push_o.n + 2'd1;
        s.failed = 1'b1;
      end
    end

    if (end_i) s = '0;
    st_d = s;
    if (!fire_i) push_o.n = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= '0;
    else if (fire_i) st_q <= st_d;
  end

endmodule
`default_nettype wire

### sv/fap_resq.sv
// Four-entry result queue: takes up to three results a cycle, gives one.
// Depends on fap_pkg.
`default_nettype none
module fap_resq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire fap_pkg::push_t push_i,
  input  wire logic           pop_i,
  output logic                room_o,
  output logic                valid_o,
  output fap_pkg::res_t       head_o
);

  fap_pkg::res_t mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q, cnt_d;

  assign valid_o = (cnt_q != 3'd0);
  assign head_o  = mem_q[rd_q];
  // three free slots after this cycle's pop
  assign room_o  = (cnt_q - {2'd0, pop_i}) <= 3'd1;
  assign cnt_d   = cnt_q - {2'd0, pop_i} + {1'b0, push_i.n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_i.n;
      rd_q  <= rd_q + {1'b0, pop_i};
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.n > 2'd1) mem_q[wr_q + 2'd1] <= push_i.r1;
    if (push_i.n > 2'd2) mem_q[wr_q + 2'd2] <= push_i.r2;
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("result queue overfilled");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 3'd0) else $error("pop from empty result queue");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> room_o) else $error("push without room");

endmodule
`default_nettype wire

### sv/form_urlencoded_argument_parser.sv
// Form-urlencoded argument parser. Raw query bytes come in on the slave
// stream, one per transfer; tlast marks the end of the query and tuser says
// whether tdata holds a byte (tuser low with tlast high is an empty end
// marker). Each accepted byte is registered, decoded once the queue has room,
// and gives up to three results, which leave a four-entry result queue one per
// cycle on the master stream while the receiver is ready. A byte is taken every
// cycle while the queue keeps up; the sustained rate is one input transfer per
// cycle, bounded by the single-result-per-cycle output port when bytes give
// several results. Results: decoded name or string bytes, argument completions
// (with the integer value) and one failure, tlast marking the final one of a
// query. After a failure the consumer discards the bytes of that query. The user
// must write configuration via cfg_we_i/cfg_idx_i only while the block is idle;
// the block does not enforce it. Depends on fap_pkg, fap_core and fap_resq.
`default_nettype none
module form_urlencoded_argument_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] has_byte
  input  wire logic        s_axis_tlast_i,   // end_of_query
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // [2:0] arg_index, [10:3] out_byte,
                                             // [42:11] int_value, rest zero
  output logic [1:0]       m_axis_tuser_o,   // [1:0] kind
  output logic             m_axis_tlast_o,   // query_done
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  logic        in_vld_q, in_has_q, in_end_q;
  logic [7:0]  in_byte_q;
  logic [3:0]  count_q;
  logic [15:0] types_q;
  logic        room, fire, pop;
  fap_pkg::push_t push;
  fap_pkg::res_t  head;

  // input register frees when its byte is decoded
  assign fire = in_vld_q && room;
  assign s_axis_tready_o = !in_vld_q || fire;
  assign pop = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else if (s_axis_tready_o) in_vld_q <= s_axis_tvalid_i;
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_has_q  <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i;
      in_end_q  <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 4'd1;
      types_q <= 16'hAAAA;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fap_pkg::CFG_COUNT) count_q <= cfg_wdata_i[3:0];
      else types_q <= cfg_wdata_i;
    end
  end

  fap_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .has_i   (in_has_q),
    .byte_i  (in_byte_q),
    .end_i   (in_end_q),
    .count_i (count_q),
    .types_i (types_q),
    .push_o  (push)
  );

  fap_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .head_o  (head)
  );

  assign m_axis_tdata_o = {5'd0, head.int_value, head.out_byte, head.arg_index};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.query_done;

endmodule
`default_nettype wire

### tb/sv/form_urlencoded_argument_parser_test.sv
// Testbench for form_urlencoded_argument_parser: random and directed query strings,
// results checked against a behavioural predictor held in a scoreboard class.
// Depends on fap_pkg and the parser RTL.
`timescale 1ns / 1ps
module form_urlencoded_argument_parser_test;

  typedef struct {
    fap_pkg::kind_e kind;
    logic [2:0]     arg_index;
    logic [7:0]     out_byte;
    logic [31:0]    int_value;
    logic           query_done;
  } parse_res_t;

  // Predictor of the parser plus the queue of results still owed.
  class query_scoreboard;
    logic [3:0]  arg_cnt;
    logic [15:0] arg_types;
    int unsigned cur, esc, hi, u8p, u8r, nph, ngot, iph, ineg, iovf, failed;
    logic [31:0] imag;
    parse_res_t  owed[$];
    int          errors;

    function void reset_all();
      arg_cnt = 1;
      arg_types = 16'hAAAA;
      clear_query();
      owed.delete();
      errors = 0;
    endfunction

    function void clear_arg();
      esc = fap_pkg::ESC_NONE; hi = 0; u8p = 0; u8r = fap_pkg::U8R_ANY;
      nph = fap_pkg::NPH_LEAD; ngot = 0;
      iph = fap_pkg::IPH_LEAD; ineg = 0; imag = 0; iovf = 0;
    endfunction

    function void clear_query();
      clear_arg();
      cur = 0;
      failed = 0;
    endfunction

    function void push(fap_pkg::kind_e k, int unsigned b, logic [31:0] v, bit done);
      parse_res_t r;
      r.kind = k; r.arg_index = cur[2:0]; r.out_byte = b[7:0];
      r.int_value = v; r.query_done = done;
      owed.push_back(r);
    endfunction

    function int unsigned final_index();
      int unsigned c;
      c = arg_cnt;
      if (c < 1) c = 1;
      if (c > fap_pkg::MaxArgs) c = fap_pkg::MaxArgs;
      return c - 1;
    endfunction

    function int unsigned cur_type();
      int unsigned t;
      t = (cur < 8) ? (arg_types >> (2 * cur)) & 3 : 0;
      return (t == 3) ? fap_pkg::TY_STR : t;
    endfunction

    function int hex_digit(int unsigned c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function bit ws(int unsigned c);
      return c == 32 || (c >= 9 && c <= 13);
    endfunction

    function bit utf8_step(int unsigned c);
      int unsigned lo, hb;
      if (u8p == 0) begin
        if (c == 0 || (c >= 8'h80 && c < 8'hC2) || c > 8'hF4) return 0;
        if (c < 8'h80) return 1;
        if (c < 8'hE0) begin u8p = 1; u8r = fap_pkg::U8R_ANY; end
        else if (c == 8'hE0) begin u8p = 2; u8r = fap_pkg::U8R_A0BF; end
        else if (c == 8'hED) begin u8p = 2; u8r = fap_pkg::U8R_809F; end
        else if (c < 8'hF0) begin u8p = 2; u8r = fap_pkg::U8R_ANY; end
        else if (c == 8'hF0) begin u8p = 3; u8r = fap_pkg::U8R_90BF; end
        else if (c < 8'hF4) begin u8p = 3; u8r = fap_pkg::U8R_ANY; end
        else begin u8p = 3; u8r = fap_pkg::U8R_808F; end
        return 1;
      end
      lo = 8'h80; hb = 8'hBF;
      case (u8r)
        fap_pkg::U8R_A0BF: lo = 8'hA0;
        fap_pkg::U8R_809F: hb = 8'h9F;
        fap_pkg::U8R_90BF: lo = 8'h90;
        fap_pkg::U8R_808F: hb = 8'h8F;
        default: ;
      endcase
      if (c < lo || c > hb) return 0;
      u8p--; u8r = fap_pkg::U8R_ANY;
      return 1;
    endfunction

    function bit take_byte(int unsigned c);
      int unsigned t;
      longint unsigned m, lim;
      if (!utf8_step(c)) return 0;
      t = cur_type();
      if (t == fap_pkg::TY_INT) begin
        if (iph == fap_pkg::IPH_LEAD) begin
          if (ws(c)) return 1;
          if (c == "+" || c == "-") begin
            ineg = (c == "-");
            iph = fap_pkg::IPH_SIGN;
            return 1;
          end
        end
        if (c < "0" || c > "9") return 0;
        iph = fap_pkg::IPH_DIG;
        if (!iovf) begin
          m = longint'(imag) * 10 + (c - "0");
          lim = ineg ? 64'd2147483648 : 64'd2147483647;
          if (m > lim) iovf = 1; else imag = m[31:0];
        end
        return 1;
      end
      if (t == fap_pkg::TY_NAME) begin
        if (ws(c)) begin
          if (nph == fap_pkg::NPH_WORD) nph = fap_pkg::NPH_SPACE;
          return 1;
        end
        if (c <= 32) return 0;
        if (nph == fap_pkg::NPH_SPACE) push(fap_pkg::KIND_BYTE, 32, 0, 0);
        push(fap_pkg::KIND_BYTE, c, 0, 0);
        nph = fap_pkg::NPH_WORD; ngot = 1;
        return 1;
      end
      push(fap_pkg::KIND_BYTE, c, 0, 0);
      return 1;
    endfunction

    function bit end_arg(bit final_arg);
      int unsigned t;
      logic [31:0] v;
      t = cur_type();
      v = 0;
      if (esc != fap_pkg::ESC_NONE || u8p != 0) return 0;
      if (t == fap_pkg::TY_INT) begin
        if (iph != fap_pkg::IPH_DIG || iovf) return 0;
        v = ineg ? -imag : imag;
      end else if (t == fap_pkg::TY_NAME && !ngot) return 0;
      if (final_arg) begin
        if (cur != final_index()) return 0;
        push(fap_pkg::KIND_DONE, 0, v, 1);
      end else begin
        if (cur >= final_index()) return 0;
        push(fap_pkg::KIND_DONE, 0, v, 0);
        cur++;
        clear_arg();
      end
      return 1;
    endfunction

    // Note one accepted input transfer.
    function void note_input(bit has, logic [7:0] b, bit eoq);
      bit ok;
      int h;
      ok = 1;
      if (failed) begin
        if (eoq) clear_query();
        return;
      end
      if (has) begin
        if (esc != fap_pkg::ESC_NONE) begin
          h = hex_digit(b);
          if (h < 0) ok = 0;
          else if (esc == fap_pkg::ESC_HI) begin hi = h; esc = fap_pkg::ESC_LO; end
          else begin esc = fap_pkg::ESC_NONE; ok = take_byte((hi << 4) | h); end
        end else if (b == "&") ok = end_arg(0);
        else if (b == "%") esc = fap_pkg::ESC_HI;
        else if (b == "+") ok = take_byte(32);
        else ok = take_byte(b);
      end
      if (ok && eoq) ok = end_arg(1);
      if (!ok) begin
        push(fap_pkg::KIND_FAIL, 0, 0, 1);
        failed = 1;
      end
      if (eoq) clear_query();
    endfunction

    function void mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endfunction

    // Compare one result transfer with the oldest owed result.
    function void check_result(logic [1:0] kind, logic [2:0] idx, logic [7:0] b,
                               logic [31:0] v, logic done);
      parse_res_t e;
      if (owed.size() == 0) begin
        mismatch($sformatf("unexpected result kind %0d", kind));
        return;
      end
      e = owed.pop_front();
      if (kind !== e.kind || idx !== e.arg_index || b !== e.out_byte ||
          v !== e.int_value || done !== e.query_done)
        mismatch($sformatf("got k%0d i%0d b%02h v%08h d%0d, want k%0d i%0d b%02h v%08h d%0d",
                 kind, idx, b, v, done, e.kind, e.arg_index, e.out_byte,
                 e.int_value, e.query_done));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;   // [7:0] data_byte
  logic        s_axis_tuser_i = 1'b0; // [0] has_byte
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;        // [2:0] arg_index, [10:3] out_byte, [42:11] int_value
  logic [1:0]  m_axis_tuser_o;        // [1:0] kind
  logic        m_axis_tlast_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  form_urlencoded_argument_parser i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  query_scoreboard board = new();
  int  send_idle_pct, recv_idle_pct;
  bit  recv_hold;      // long receiver hold-off while the sender keeps offering
  int  quiet_cycles;
  bit  finished;

  // Record transfers on both sides; the predictor runs at the accepting edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        board.note_input(s_axis_tuser_i, s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        board.check_result(m_axis_tuser_o, m_axis_tdata_o[2:0], m_axis_tdata_o[10:3],
                           m_axis_tdata_o[42:11], m_axis_tlast_o);
    end
  end

  // Receiver: random stalls, or a full hold-off when asked.
  always @(posedge clk_i) begin
    if (recv_hold) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        !rst_ni || finished)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 4000) begin
      $display("form_urlencoded_argument_parser_test: FAIL");
      $finish;
    end
  end

  // One input transfer, with random idle cycles ahead of it. Valid stays up
  // after the transfer; the next item, an idle cycle or drain() replaces it.
  task automatic send_item(bit has, logic [7:0] b, bit eoq);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= has;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= eoq;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic send_text(string s, bit close_query);
    for (int i = 0; i < s.len(); i++)
      send_item(1'b1, s[i], close_query && i == s.len() - 1);
  endtask

  // Wait for every owed result, then let the clock run on for any late work.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == fap_pkg::CFG_COUNT) board.arg_cnt = v[3:0];
    else board.arg_types = v;
    @(posedge clk_i);
  endtask

  // A random byte of argument content, biased towards meaningful characters.
  function automatic logic [7:0] pick_byte(int unsigned ty);
    case ($urandom_range(9))
      0: return 8'($urandom_range(255));
      1: return " ";
      2: return "+";
      3, 4: return (ty == fap_pkg::TY_INT) ? 8'("0" + $urandom_range(9))
                                           : 8'("a" + $urandom_range(25));
      5: return 8'("0" + $urandom_range(9));
      6: return "%";
      7: return "-";
      default: return (ty == fap_pkg::TY_INT) ? 8'("0" + $urandom_range(9))
                                              : 8'(8'h21 + $urandom_range(93));
    endcase
  endfunction

  // A mostly well-formed query for the current setting.
  task automatic send_query(inout int left);
    int unsigned nargs, ty, len;
    string hexs;
    nargs = board.final_index() + 1;
    if ($urandom_range(9) == 0) nargs = $urandom_range(1, 9);
    for (int a = 0; a < nargs; a++) begin
      ty = (a < 8) ? (board.arg_types >> (2 * a)) & 3 : 0;
      len = $urandom_range(0, 5);
      if ($urandom_range(3) == 0 && ty != fap_pkg::TY_INT) begin
        // percent escapes, often a valid multi-byte sequence
        case ($urandom_range(3))
          0: hexs = "%C3%A9";
          1: hexs = "%E2%82%AC";
          2: hexs = "%F0%9F%98%80";
          default: hexs = $sformatf("%%%02X", $urandom_range(255));
        endcase
        send_text(hexs, 0);
        left -= hexs.len();
      end
      if (ty == fap_pkg::TY_INT && $urandom_range(3) == 0) begin
        hexs = $sformatf("%0d", $signed($urandom()));
        send_text(hexs, 0);
        left -= hexs.len();
      end
      for (int i = 0; i < len; i++) begin
        send_item(1'b1, pick_byte(ty), 1'b0);
        left--;
      end
      if (a != nargs - 1) begin send_item(1'b1, "&", 1'b0); left--; end
    end
    if ($urandom_range(1)) send_item(1'b0, 8'($urandom_range(255)), 1'b1);
    else send_item(1'b1, ty == fap_pkg::TY_INT ? "7" : "z", 1'b1);
    left--;
  endtask

  int left;
  bit [15:0] types_list[5] = '{16'h0000, 16'h5555, 16'hAAAA, 16'hFFFF, 16'h1B64};

  initial begin
    board.reset_all();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 0;
    finished = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: defaults (one string argument), then special cases.
    send_text("a+b%41%ff", 1);
    send_item(1'b0, 8'h00, 1'b0);               // empty step: nothing happens
    send_item(1'b0, 8'hFF, 1'b1);               // empty end marker on empty string
    drain();
    write_reg(fap_pkg::CFG_COUNT, 16'd3);
    write_reg(fap_pkg::CFG_TYPES, 16'b10_01_00); // int, name, string
    send_text(" -2147483648&  x\ty +z&%00", 1); // NUL fails the last argument
    send_text("2147483648&n&s", 1);             // overflow
    send_text("+12&%C2%80&%ED%A0%80", 1);       // surrogate rejected
    send_text("1&a&b&c", 1);                    // too many separators
    send_text("5&a", 1);                        // too few
    send_text("5&a&%4", 1);                     // escape cut short
    drain();
    write_reg(fap_pkg::CFG_COUNT, 16'd0);       // acts as one
    write_reg(fap_pkg::CFG_TYPES, 16'hFFFF);    // code 3: string
    send_text("%F4%8F%BF%BF%E0%A0%80", 1);
    drain();

    // Random phases: several settings, idling per phase.
    left = 360;
    for (int ph = 0; left > 0; ph++) begin
      write_reg(fap_pkg::CFG_COUNT, (ph % 3 == 0) ? 16'd8 : (ph % 5 == 0) ? 16'hF :
                16'($urandom_range(1, 9)));
      write_reg(fap_pkg::CFG_TYPES, (ph < 5) ? types_list[ph] : 16'($urandom()));
      if (left > 240) begin send_idle_pct = 34; recv_idle_pct = 67; end
      else if (left > 120) begin send_idle_pct = 67; recv_idle_pct = 34; end
      else begin send_idle_pct = 0; recv_idle_pct = 0; end
      if (ph == 2) begin
        // Long receiver hold-off with the sender still offering.
        fork
          begin
            recv_hold = 1;
            repeat (60) @(posedge clk_i);
            recv_hold = 0;
          end
          begin
            for (int q = 0; q < 3; q++) send_query(left);
          end
        join
      end
      for (int q = 0; q < 4 && left > 0; q++) send_query(left);
      drain();   // sender pauses until all results are in
    end

    drain();
    finished = 1;
    repeat (20) @(posedge clk_i);
    if (board.owed.size() != 0) board.mismatch("results still owed at the end");
    if (board.errors == 0) $display("form_urlencoded_argument_parser_test: PASS");
    else $display("form_urlencoded_argument_parser_test: FAIL");
    $finish;
  end
endmodule
